// File: rtl/acbc_pkg.sv
// Shared constants, types and register codes for the alpha composite autocrop block.
package acbc_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_SIZE_W  = 13;
  localparam int unsigned MAX_DIM_DEF = 4096;

  // Padding is max(PAD_MIN, size / 20); size / 20 = (size * PAD_RECIP) >> PAD_SHIFT,
  // exact for sizes below 43690.
  localparam int unsigned PAD_MIN   = 10;
  localparam int unsigned PAD_RECIP = 26215;
  localparam int unsigned PAD_SHIFT = 19;
  localparam int unsigned RECIP_W   = 15;

  localparam logic [PIX_W-1:0] ALPHA_MAX    = 8'hFF;
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BG_RED    = 3'd0,
    REG_BG_GREEN  = 3'd1,
    REG_BG_BLUE   = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5,
    REG_ALPHA_EN  = 3'd6
  } acbc_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } acbc_pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } acbc_rgb_t;

  typedef struct packed {
    acbc_rgb_t        bg;
    logic [PIX_W-1:0] threshold;
    logic             alpha_en;
  } acbc_colour_cfg_t;

  typedef struct packed {
    logic done;
    logic empty;
  } acbc_frame_t;

endpackage

// File: rtl/acbc_if.sv
// Stream interfaces for the pixel input and the result output.
interface acbc_pix_if;
  logic                       valid;
  logic                       ready;
  logic [acbc_pkg::PIX_W-1:0] pix_red;
  logic [acbc_pkg::PIX_W-1:0] pix_green;
  logic [acbc_pkg::PIX_W-1:0] pix_blue;
  logic [acbc_pkg::PIX_W-1:0] pix_alpha;

  modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, input ready);
  modport sink   (input valid, pix_red, pix_green, pix_blue, pix_alpha, output ready);
endinterface

interface acbc_res_if #(
  parameter int unsigned COORD_W = $clog2(acbc_pkg::MAX_DIM_DEF),
  parameter int unsigned DIM_W   = $clog2(acbc_pkg::MAX_DIM_DEF + 1)
);
  logic                       valid;
  logic                       ready;
  logic [acbc_pkg::PIX_W-1:0] out_red;
  logic [acbc_pkg::PIX_W-1:0] out_green;
  logic [acbc_pkg::PIX_W-1:0] out_blue;
  logic                       frame_done;
  logic                       frame_empty;
  logic [COORD_W-1:0]         crop_left;
  logic [COORD_W-1:0]         crop_top;
  logic [DIM_W-1:0]           crop_width;
  logic [DIM_W-1:0]           crop_height;

  modport source (output valid, out_red, out_green, out_blue, frame_done, frame_empty,
                  crop_left, crop_top, crop_width, crop_height, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_done, frame_empty,
                  crop_left, crop_top, crop_width, crop_height, output ready);
endinterface

// File: rtl/acbc_cfg_regs.sv
// Configuration registers with frame size clamping at write time.
module acbc_cfg_regs #(
  parameter int unsigned MAX_DIM = acbc_pkg::MAX_DIM_DEF,
  parameter int unsigned COORD_W = $clog2(MAX_DIM),
  parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [acbc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [acbc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output acbc_pkg::acbc_colour_cfg_t          colour_o,
  output logic [DIM_W-1:0]                    w_eff_o,
  output logic [DIM_W-1:0]                    h_eff_o,
  output logic [COORD_W-1:0]                  w_last_o,
  output logic [COORD_W-1:0]                  h_last_o
);
  import acbc_pkg::*;

  localparam int unsigned CMP_W = (CFG_SIZE_W > DIM_W) ? CFG_SIZE_W : DIM_W;

  acbc_colour_cfg_t   colour_q;
  logic [DIM_W-1:0]   w_eff_q, h_eff_q, size_eff;
  logic [COORD_W-1:0] w_last_q, h_last_q, size_last;
  logic [CMP_W-1:0]   size_raw;

  // Zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    size_raw = CMP_W'(cfg_wdata_i[CFG_SIZE_W-1:0]);
    if (size_raw == '0) begin
      size_eff = DIM_W'(1);
    end else if (size_raw > CMP_W'(MAX_DIM)) begin
      size_eff = DIM_W'(MAX_DIM);
    end else begin
      size_eff = size_raw[DIM_W-1:0];
    end
    size_last = COORD_W'(size_eff - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q.bg.red    <= '0;
      colour_q.bg.green  <= '0;
      colour_q.bg.blue   <= '0;
      colour_q.threshold <= THRESH_RESET;
      colour_q.alpha_en  <= 1'b1;
      w_eff_q            <= DIM_W'(MAX_DIM);
      h_eff_q            <= DIM_W'(MAX_DIM);
      w_last_q           <= COORD_W'(MAX_DIM - 1);
      h_last_q           <= COORD_W'(MAX_DIM - 1);
    end else if (cfg_we_i) begin
      unique case (acbc_reg_e'(cfg_idx_i))
        REG_BG_RED:    colour_q.bg.red    <= cfg_wdata_i[PIX_W-1:0];
        REG_BG_GREEN:  colour_q.bg.green  <= cfg_wdata_i[PIX_W-1:0];
        REG_BG_BLUE:   colour_q.bg.blue   <= cfg_wdata_i[PIX_W-1:0];
        REG_THRESHOLD: colour_q.threshold <= cfg_wdata_i[PIX_W-1:0];
        REG_WIDTH: begin
          w_eff_q  <= size_eff;
          w_last_q <= size_last;
        end
        REG_HEIGHT: begin
          h_eff_q  <= size_eff;
          h_last_q <= size_last;
        end
        REG_ALPHA_EN:  colour_q.alpha_en  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign colour_o = colour_q;
  assign w_eff_o  = w_eff_q;
  assign h_eff_o  = h_eff_q;
  assign w_last_o = w_last_q;
  assign h_last_o = h_last_q;

endmodule

// File: rtl/acbc_blend.sv
// Alpha blend onto the background colour and content test of one pixel.
module acbc_blend (
  input  acbc_pkg::acbc_pix_t        pix_i,
  input  acbc_pkg::acbc_colour_cfg_t colour_i,
  output acbc_pkg::acbc_rgb_t        rgb_o,
  output logic                       content_o
);
  import acbc_pkg::*;

  // (c*a + bg*(255-a)) / 255, with the divide done as (n + (n >> 8) + 1) >> 8.
  function automatic logic [PIX_W-1:0] blend_ch(input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] bg,
                                                input logic [PIX_W-1:0] a);
    logic [2*PIX_W-1:0] num;
    logic [2*PIX_W-1:0] acc;
    num = (2*PIX_W)'(c) * (2*PIX_W)'(a) + (2*PIX_W)'(bg) * (2*PIX_W)'(ALPHA_MAX - a);
    acc = num + (num >> PIX_W) + (2*PIX_W)'(1);
    return acc[2*PIX_W-1:PIX_W];
  endfunction

  function automatic logic differs(input logic [PIX_W-1:0] c,
                                   input logic [PIX_W-1:0] bg,
                                   input logic [PIX_W-1:0] thr);
    logic [PIX_W-1:0] d;
    d = (c > bg) ? c - bg : bg - c;
    return d > thr;
  endfunction

  always_comb begin
    if (colour_i.alpha_en) begin
      rgb_o.red   = blend_ch(pix_i.red,   colour_i.bg.red,   pix_i.alpha);
      rgb_o.green = blend_ch(pix_i.green, colour_i.bg.green, pix_i.alpha);
      rgb_o.blue  = blend_ch(pix_i.blue,  colour_i.bg.blue,  pix_i.alpha);
    end else begin
      rgb_o.red   = pix_i.red;
      rgb_o.green = pix_i.green;
      rgb_o.blue  = pix_i.blue;
    end
    content_o = differs(rgb_o.red,   colour_i.bg.red,   colour_i.threshold)
             || differs(rgb_o.green, colour_i.bg.green, colour_i.threshold)
             || differs(rgb_o.blue,  colour_i.bg.blue,  colour_i.threshold);
  end

endmodule

// File: rtl/acbc_pad_axis.sv
// Pad one axis of the bounding box and clamp it to the image.
module acbc_pad_axis #(
  parameter int unsigned COORD_W = 12,
  parameter int unsigned DIM_W   = 13
) (
  input  logic [COORD_W-1:0] lo_i,
  input  logic [COORD_W-1:0] hi_i,
  input  logic [DIM_W-1:0]   dim_i,
  output logic [COORD_W-1:0] start_o,
  output logic [DIM_W-1:0]   len_o
);
  import acbc_pkg::*;

  localparam int unsigned PROD_W = DIM_W + RECIP_W;
  localparam int unsigned SPAN_W = DIM_W + 2;

  logic [DIM_W-1:0]  content, pad, quot, lo_ext, start_w;
  logic [PROD_W-1:0] prod;
  logic [SPAN_W-1:0] span;
  logic [DIM_W:0]    room;
  logic              clamp;

  always_comb begin
    lo_ext  = DIM_W'(lo_i);
    content = DIM_W'(hi_i) - lo_ext + DIM_W'(1);
    prod    = PROD_W'(content) * PROD_W'(PAD_RECIP);
    quot    = DIM_W'(prod >> PAD_SHIFT);
    pad     = (quot < DIM_W'(PAD_MIN)) ? DIM_W'(PAD_MIN) : quot;
    start_w = (lo_ext > pad) ? lo_ext - pad : '0;
    span    = SPAN_W'(content) + SPAN_W'({pad, 1'b0});
    // A start beyond the image leaves no room to clamp to: keep the span.
    room    = (DIM_W + 1)'(dim_i) - (DIM_W + 1)'(start_w);
    clamp   = !room[DIM_W] && (span > SPAN_W'(room[DIM_W-1:0]));
    start_o = COORD_W'(start_w);
    len_o   = clamp ? room[DIM_W-1:0] : DIM_W'(span);
  end

endmodule

// File: rtl/acbc_bbox.sv
// Raster position, content bounding box and crop result at frame end.
module acbc_bbox #(
  parameter int unsigned COORD_W = 12,
  parameter int unsigned DIM_W   = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  content_i,
  input  logic [DIM_W-1:0]      w_eff_i,
  input  logic [DIM_W-1:0]      h_eff_i,
  input  logic [COORD_W-1:0]    w_last_i,
  input  logic [COORD_W-1:0]    h_last_i,
  output acbc_pkg::acbc_frame_t frame_o,
  output logic [COORD_W-1:0]    crop_left_o,
  output logic [COORD_W-1:0]    crop_top_o,
  output logic [DIM_W-1:0]      crop_width_o,
  output logic [DIM_W-1:0]      crop_height_o
);
  import acbc_pkg::*;

  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               seen_q, seen_d;
  logic [COORD_W-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic [COORD_W-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic [COORD_W-1:0] c_min_x, c_max_x, c_min_y, c_max_y;
  logic [COORD_W-1:0] nx_start, ox_start, ny_start, oy_start;
  logic [DIM_W-1:0]   nx_len, ox_len, ny_len, oy_len;
  logic               row_end, last;

  // Box with the current pixel merged in; its reset value never survives.
  always_comb begin
    if (seen_q) begin
      c_min_x = (col_q < min_x_q) ? col_q : min_x_q;
      c_max_x = (col_q > max_x_q) ? col_q : max_x_q;
      c_min_y = (row_q < min_y_q) ? row_q : min_y_q;
      c_max_y = (row_q > max_y_q) ? row_q : max_y_q;
    end else begin
      c_min_x = col_q;
      c_max_x = col_q;
      c_min_y = row_q;
      c_max_y = row_q;
    end
  end

  // Pad both candidate boxes in parallel, pick by content afterwards.
  acbc_pad_axis #(.COORD_W(COORD_W), .DIM_W(DIM_W)) u_pad_x_new (
    .lo_i(c_min_x), .hi_i(c_max_x), .dim_i(w_eff_i), .start_o(nx_start), .len_o(nx_len)
  );
  acbc_pad_axis #(.COORD_W(COORD_W), .DIM_W(DIM_W)) u_pad_x_old (
    .lo_i(min_x_q), .hi_i(max_x_q), .dim_i(w_eff_i), .start_o(ox_start), .len_o(ox_len)
  );
  acbc_pad_axis #(.COORD_W(COORD_W), .DIM_W(DIM_W)) u_pad_y_new (
    .lo_i(c_min_y), .hi_i(c_max_y), .dim_i(h_eff_i), .start_o(ny_start), .len_o(ny_len)
  );
  acbc_pad_axis #(.COORD_W(COORD_W), .DIM_W(DIM_W)) u_pad_y_old (
    .lo_i(min_y_q), .hi_i(max_y_q), .dim_i(h_eff_i), .start_o(oy_start), .len_o(oy_len)
  );

  always_comb begin
    row_end = (col_q >= w_last_i);
    last    = row_end && (row_q >= h_last_i);

    frame_o.done  = last;
    frame_o.empty = last && !(seen_q || content_i);
    crop_left_o   = '0;
    crop_top_o    = '0;
    crop_width_o  = '0;
    crop_height_o = '0;
    if (frame_o.empty) begin
      crop_width_o  = w_eff_i;
      crop_height_o = h_eff_i;
    end else if (last) begin
      crop_left_o   = content_i ? nx_start : ox_start;
      crop_width_o  = content_i ? nx_len   : ox_len;
      crop_top_o    = content_i ? ny_start : oy_start;
      crop_height_o = content_i ? ny_len   : oy_len;
    end

    col_d   = col_q;
    row_d   = row_q;
    seen_d  = seen_q;
    min_x_d = min_x_q;
    max_x_d = max_x_q;
    min_y_d = min_y_q;
    max_y_d = max_y_q;
    if (step_i) begin
      if (last) begin
        col_d   = '0;
        row_d   = '0;
        seen_d  = 1'b0;
        min_x_d = '1;
        max_x_d = '0;
        min_y_d = '1;
        max_y_d = '0;
      end else begin
        if (content_i) begin
          seen_d  = 1'b1;
          min_x_d = c_min_x;
          max_x_d = c_max_x;
          min_y_d = c_min_y;
          max_y_d = c_max_y;
        end
        if (row_end) begin
          col_d = '0;
          row_d = row_q + COORD_W'(1);
        end else begin
          col_d = col_q + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      seen_q  <= 1'b0;
      min_x_q <= '1;
      max_x_q <= '0;
      min_y_q <= '1;
      max_y_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      seen_q  <= seen_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
  end

endmodule

// File: rtl/alpha_composite_content_bbox_crop_top.sv
// Alpha composite pixel stream with content bounding box autocrop, top level.
// Path: a pixel taken into the input register moves on into the result register on
//   res_out when that is free or emptied, through blend, content test and crop logic.
// Throughput: one pixel per cycle unless res_out stalls, set by the single pass.
// Reset: clears both valid flags, the raster position and the box, and loads the
//   configuration defaults; no clearing pass, items are accepted right after reset.
module alpha_composite_content_bbox_crop_top #(
  parameter int unsigned MAX_DIM = acbc_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [acbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  acbc_pix_if.sink                        pix_in,
  acbc_res_if.source                      res_out
);
  import acbc_pkg::*;

  localparam int unsigned COORD_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);

  acbc_colour_cfg_t   colour;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] w_last, h_last;

  acbc_pix_t          pix_q;
  logic               in_vld_q, in_vld_d;
  logic               advance;

  acbc_rgb_t          rgb;
  logic               content;
  acbc_frame_t        frame;
  logic [COORD_W-1:0] crop_left, crop_top;
  logic [DIM_W-1:0]   crop_width, crop_height;

  acbc_rgb_t          rgb_q;
  acbc_frame_t        frame_q;
  logic [COORD_W-1:0] crop_left_q, crop_top_q;
  logic [DIM_W-1:0]   crop_width_q, crop_height_q;
  logic               out_vld_q, out_vld_d;

  acbc_cfg_regs #(.MAX_DIM(MAX_DIM), .COORD_W(COORD_W), .DIM_W(DIM_W)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .colour_o   (colour),
    .w_eff_o    (w_eff),
    .h_eff_o    (h_eff),
    .w_last_o   (w_last),
    .h_last_o   (h_last)
  );

  // Move the held pixel on whenever the result register is free or being emptied;
  // take a new pixel whenever the input register is free or moving on.
  assign advance      = in_vld_q && (!out_vld_q || res_out.ready);
  assign pix_in.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (pix_in.valid && pix_in.ready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (res_out.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the pixel payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (pix_in.valid && pix_in.ready) begin
      pix_q.red   <= pix_in.pix_red;
      pix_q.green <= pix_in.pix_green;
      pix_q.blue  <= pix_in.pix_blue;
      pix_q.alpha <= pix_in.pix_alpha;
    end
  end

  acbc_blend u_blend (
    .pix_i    (pix_q),
    .colour_i (colour),
    .rgb_o    (rgb),
    .content_o(content)
  );

  // Position and box step only when the pixel moves into the result register.
  acbc_bbox #(.COORD_W(COORD_W), .DIM_W(DIM_W)) u_bbox (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .content_i    (content),
    .w_eff_i      (w_eff),
    .h_eff_i      (h_eff),
    .w_last_i     (w_last),
    .h_last_i     (h_last),
    .frame_o      (frame),
    .crop_left_o  (crop_left),
    .crop_top_o   (crop_top),
    .crop_width_o (crop_width),
    .crop_height_o(crop_height)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rgb_q         <= rgb;
      frame_q       <= frame;
      crop_left_q   <= crop_left;
      crop_top_q    <= crop_top;
      crop_width_q  <= crop_width;
      crop_height_q <= crop_height;
    end
  end

  assign res_out.valid       = out_vld_q;
  assign res_out.out_red     = rgb_q.red;
  assign res_out.out_green   = rgb_q.green;
  assign res_out.out_blue    = rgb_q.blue;
  assign res_out.frame_done  = frame_q.done;
  assign res_out.frame_empty = frame_q.empty;
  assign res_out.crop_left   = crop_left_q;
  assign res_out.crop_top    = crop_top_q;
  assign res_out.crop_width  = crop_width_q;
  assign res_out.crop_height = crop_height_q;

endmodule

// File: tb/sv/alpha_composite_content_bbox_crop_top_test.sv
// Self-checking testbench for the alpha composite autocrop block: directed and random frames.
`timescale 1ns / 100ps

module alpha_composite_content_bbox_crop_top_test;
  import acbc_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 8;
  // Two register stages inside the block; allow a little slack after the last result.
  localparam int unsigned RESULT_LATENCY = 4;
  localparam int unsigned MAX_GAP        = 13;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RANDOM_PIXELS  = 200;
  localparam int unsigned LONG_LEAD      = 10;
  localparam int unsigned LONG_ROW       = 500;
  localparam int unsigned LONG_COL       = 300;
  localparam int unsigned PAD_DIV        = 20;
  localparam int unsigned BLEND_FULL     = 255;
  localparam int unsigned COORD_W        = 12;
  localparam int unsigned DIM_W          = 13;

  // One expected result item, field by field.
  typedef struct {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic               done;
    logic               empty;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } crop_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  acbc_pix_if pix ();
  acbc_res_if res ();

  alpha_composite_content_bbox_crop_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_in     (pix),
    .res_out    (res)
  );

  // Predictor copy of the configuration registers.
  acbc_colour_cfg_t       colour_cfg;
  logic [CFG_SIZE_W-1:0]  width_setting;
  logic [CFG_SIZE_W-1:0]  height_setting;

  // Predictor copy of the raster position and the content box.
  int unsigned col_pos;
  int unsigned row_pos;
  bit          box_valid;
  int unsigned box_x0, box_y0, box_x1, box_y1;

  crop_result_t expected_pixels[$];
  int unsigned  pixels_sent  = 0;
  int unsigned  mismatches   = 0;
  int unsigned  quiet_cycles = 0;
  // Both sides draw random gaps while this is set; clear it for full-rate stretches.
  bit           idle_on      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return the raster position and the box to their start-of-frame values.
  function automatic void clear_raster();
    col_pos   = 0;
    row_pos   = 0;
    box_valid = 1'b0;
    box_x0    = (1 << COORD_W) - 1;
    box_y0    = (1 << COORD_W) - 1;
    box_x1    = 0;
    box_y1    = 0;
  endfunction

  // Take a size register as the block does: zero counts as one, oversize as MAX_DIM.
  function automatic int unsigned clamp_size(logic [CFG_SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  // Truncating fixed-point blend of one channel onto the background.
  function automatic logic [PIX_W-1:0] blend_onto_bg(logic [PIX_W-1:0] c,
                                                     logic [PIX_W-1:0] bg,
                                                     logic [PIX_W-1:0] a);
    int unsigned ci, bi, ai, mix;
    ci  = c;
    bi  = bg;
    ai  = a;
    mix = ci * ai + bi * (BLEND_FULL - ai);
    return PIX_W'(mix / BLEND_FULL);
  endfunction

  function automatic bit far_from_bg(logic [PIX_W-1:0] c, logic [PIX_W-1:0] bg);
    int unsigned d;
    d = (c > bg) ? int'(c) - int'(bg) : int'(bg) - int'(c);
    return d > colour_cfg.threshold;
  endfunction

  // Pad one axis of the box by max(PAD_MIN, size / 20) and clamp it to the image.
  function automatic void pad_and_clamp(input int unsigned lo, input int unsigned hi,
                                        input int unsigned dim,
                                        output int unsigned start, output int unsigned len);
    int unsigned content, pad;
    content = hi - lo + 1;
    pad     = content / PAD_DIV;
    if (pad < PAD_MIN) pad = PAD_MIN;
    start = (lo > pad) ? lo - pad : 0;
    len   = content + 2 * pad;
    if (len > dim - start) len = dim - start;
  endfunction

  // Work out the result item for one accepted pixel and advance the raster.
  function automatic crop_result_t composite_pixel(acbc_pix_t p);
    crop_result_t     r;
    int unsigned      w, h, x, y, cl, ct, cw, ch;
    logic [PIX_W-1:0] red, green, blue;
    bit               row_end;
    w     = clamp_size(width_setting);
    h     = clamp_size(height_setting);
    x     = col_pos;
    y     = row_pos;
    red   = p.red;
    green = p.green;
    blue  = p.blue;
    if (colour_cfg.alpha_en) begin
      red   = blend_onto_bg(p.red, colour_cfg.bg.red, p.alpha);
      green = blend_onto_bg(p.green, colour_cfg.bg.green, p.alpha);
      blue  = blend_onto_bg(p.blue, colour_cfg.bg.blue, p.alpha);
    end
    // Grow the box with every content pixel; the first one loads it outright.
    if (far_from_bg(red, colour_cfg.bg.red) || far_from_bg(green, colour_cfg.bg.green) ||
        far_from_bg(blue, colour_cfg.bg.blue)) begin
      if (!box_valid) begin
        box_x0    = x;
        box_x1    = x;
        box_y0    = y;
        box_y1    = y;
        box_valid = 1'b1;
      end else begin
        if (x < box_x0) box_x0 = x;
        if (x > box_x1) box_x1 = x;
        if (y < box_y0) box_y0 = y;
        if (y > box_y1) box_y1 = y;
      end
    end
    r       = '{default: '0};
    r.red   = red;
    r.green = green;
    r.blue  = blue;
    // Compare with >= so that a size shrunk mid-frame still ends the row and frame.
    row_end = (x >= w - 1);
    if (row_end && (y >= h - 1)) begin
      r.done = 1'b1;
      if (!box_valid) begin
        r.empty  = 1'b1;
        r.width  = DIM_W'(w);
        r.height = DIM_W'(h);
      end else begin
        pad_and_clamp(box_x0, box_x1, w, cl, cw);
        pad_and_clamp(box_y0, box_y1, h, ct, ch);
        r.left   = COORD_W'(cl);
        r.top    = COORD_W'(ct);
        r.width  = DIM_W'(cw);
        r.height = DIM_W'(ch);
      end
      clear_raster();
    end else if (row_end) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one accepted result item with the oldest expectation.
  function automatic void check_result();
    crop_result_t want;
    if (expected_pixels.size() == 0) begin
      $error("result item arrived with nothing expected");
      mismatches++;
      return;
    end
    want = expected_pixels.pop_front();
    check_field("out_red", want.red, res.out_red);
    check_field("out_green", want.green, res.out_green);
    check_field("out_blue", want.blue, res.out_blue);
    check_field("frame_done", want.done, res.frame_done);
    check_field("frame_empty", want.empty, res.frame_empty);
    check_field("crop_left", want.left, res.crop_left);
    check_field("crop_top", want.top, res.crop_top);
    check_field("crop_width", want.width, res.crop_width);
    check_field("crop_height", want.height, res.crop_height);
  endfunction

  // Hold ready low for a random stall before each result item, then take it.
  initial begin : result_sink
    int unsigned stall;
    res.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      // Values read right after the edge are those the block saw at the edge.
      do @(posedge clk_i); while (res.valid !== 1'b1);
      check_result();
    end
  end

  // Drop the run if neither side moves an item for too long.
  always @(posedge clk_i) begin : watchdog
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side and configuration
  // ---------------------------------------------------------------------------

  // Send one pixel after a random gap; keep valid high if the next one follows at once.
  task automatic send_rgba(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                           input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
    int unsigned gap;
    acbc_pix_t   p;
    p   = {r, g, b, a};
    gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid     <= 1'b1;
    pix.pix_red   <= r;
    pix.pix_green <= g;
    pix.pix_blue  <= b;
    pix.pix_alpha <= a;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
    expected_pixels.insert(expected_pixels.size(), composite_pixel(p));
    pixels_sent++;
  endtask

  // Drop valid, wait for every outstanding result item, then let the pipeline empty.
  task automatic settle_block();
    pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  // Drive one register write; the caller lowers the write enable after the last one.
  task automatic put_reg(input acbc_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_BG_RED:    colour_cfg.bg.red   = data[PIX_W-1:0];
      REG_BG_GREEN:  colour_cfg.bg.green = data[PIX_W-1:0];
      REG_BG_BLUE:   colour_cfg.bg.blue  = data[PIX_W-1:0];
      REG_THRESHOLD: colour_cfg.threshold = data[PIX_W-1:0];
      REG_WIDTH:     width_setting  = data[CFG_SIZE_W-1:0];
      REG_HEIGHT:    height_setting = data[CFG_SIZE_W-1:0];
      REG_ALPHA_EN:  colour_cfg.alpha_en = data[0];
      default: ;
    endcase
  endtask

  // Write the whole register set with the block idle.
  task automatic write_setup(input logic [PIX_W-1:0] bg_r, input logic [PIX_W-1:0] bg_g,
                             input logic [PIX_W-1:0] bg_b, input logic [PIX_W-1:0] thresh,
                             input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h,
                             input logic alpha_on);
    settle_block();
    put_reg(REG_BG_RED, CFG_DATA_W'(bg_r));
    put_reg(REG_BG_GREEN, CFG_DATA_W'(bg_g));
    put_reg(REG_BG_BLUE, CFG_DATA_W'(bg_b));
    put_reg(REG_THRESHOLD, CFG_DATA_W'(thresh));
    put_reg(REG_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_HEIGHT, CFG_DATA_W'(h));
    put_reg(REG_ALPHA_EN, CFG_DATA_W'(alpha_on));
    cfg_we_i <= 1'b0;
  endtask

  // A level just inside or just outside the threshold around a background level.
  function automatic logic [PIX_W-1:0] near_level(logic [PIX_W-1:0] bg);
    int reach, v;
    reach = int'(colour_cfg.threshold) + 1;
    v     = int'(bg) + int'($urandom_range(2 * reach, 0)) - reach;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // Random pixel: content with the given percentage, otherwise background-like.
  function automatic acbc_pix_t make_pixel(int unsigned content_pct);
    acbc_pix_t p;
    p = $urandom();
    if ($urandom_range(99, 0) >= content_pct) begin
      case ($urandom_range(2, 0))
        0: p.alpha = '0;
        1: {p.red, p.green, p.blue} = colour_cfg.bg;
        default: begin
          p.red   = near_level(colour_cfg.bg.red);
          p.green = near_level(colour_cfg.bg.green);
          p.blue  = near_level(colour_cfg.bg.blue);
          p.alpha = ALPHA_MAX;
        end
      endcase
    end
    return p;
  endfunction

  // Send random pixels until the raster is back at the start of a frame.
  task automatic send_frame_rest(input int unsigned content_pct);
    acbc_pix_t p;
    do begin
      p = make_pixel(content_pct);
      send_rgba(p.red, p.green, p.blue, p.alpha);
    end while (col_pos != 0 || row_pos != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: black background, threshold 5, blending on, full-size frame.
  task automatic test_reset_defaults();
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd0);   // transparent: lands on background
    send_rgba(8'd6, 8'd0, 8'd0, 8'd255);       // one above threshold
    send_rgba(8'd128, 8'd64, 8'd32, 8'd128);
  endtask

  // Shrink the size while the raster sits past the new row end, then mid-row.
  task automatic test_size_change_mid_frame();
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd3, 13'd2, 1'b1);
    send_rgba(8'd5, 8'd0, 8'd0, 8'd255);       // column already beyond width: ends row
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    send_rgba(8'd0, 8'd200, 8'd0, 8'd255);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255);       // frame end
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd4, 13'd3, 1'b1);
    repeat (5) send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd4, 13'd1, 1'b1);
    send_rgba(8'd0, 8'd0, 8'd90, 8'd255);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255);       // row end below the new height: frame end
  endtask

  // Single-pixel frames, including sizes of zero that count as one.
  task automatic test_tiny_frames();
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd1, 13'd1, 1'b1);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd0);         // empty frame
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd0, 13'd0, 1'b1);
    send_rgba(8'd9, 8'd0, 8'd0, 8'd255);
    send_rgba(8'd1, 8'd2, 8'd3, 8'd255);
  endtask

  // White background at threshold 0, then pass-through where nothing can be content.
  task automatic test_blend_extremes();
    write_setup(8'd255, 8'd255, 8'd255, 8'd0, 13'd3, 13'd1, 1'b1);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    send_rgba(8'd17, 8'd200, 8'd3, 8'd0);
    send_rgba(8'd254, 8'd255, 8'd255, 8'd255);
    write_setup(8'd255, 8'd255, 8'd255, 8'd255, 13'd3, 13'd1, 1'b0);
    send_rgba(8'd0, 8'd0, 8'd0, 8'd0);
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
    send_rgba(8'd128, 8'd1, 8'd254, 8'd77);
  endtask

  // One long row and one tall column at full rate: pads above the minimum and clamping.
  task automatic test_long_edges();
    idle_on = 1'b0;
    // Start the row under an oversized width register, taken as MAX_DIM, then shrink it.
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd8191, 13'd1, 1'b1);
    repeat (LONG_LEAD) send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'(LONG_ROW), 13'd1, 1'b1);
    for (int unsigned x = LONG_LEAD; x < LONG_ROW; x++) begin
      if (x == 20 || x == LONG_ROW - 1) send_rgba(8'd255, 8'd255, 8'd255, 8'd255);
      else send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    end
    write_setup(8'd0, 8'd0, 8'd0, 8'd5, 13'd1, 13'(LONG_COL), 1'b1);
    for (int unsigned y = 0; y < LONG_COL; y++) begin
      if (y == 100 || y == 110) send_rgba(8'd40, 8'd0, 8'd0, 8'd255);
      else send_rgba(8'd0, 8'd0, 8'd0, 8'd255);
    end
    idle_on = 1'b1;
  endtask

  // Random levels, favouring the ends of the range.
  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return ALPHA_MAX;
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_threshold();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return 8'd255;
      2: return 8'd254;
      default: return PIX_W'($urandom_range(40, 0));
    endcase
  endfunction

  // Whole frames of random content over random settings, some resized mid-frame.
  task automatic test_random_frames();
    int unsigned first, frame_no, pct, w, h, cut;
    acbc_pix_t   p;
    first    = pixels_sent;
    frame_no = 0;
    while (pixels_sent - first < RANDOM_PIXELS) begin
      idle_on = ($urandom_range(3, 0) != 0);
      if (frame_no == 0 || $urandom_range(2, 0) == 0) begin
        // Mostly small frames; a few wide strips so the pad exceeds its minimum.
        if ($urandom_range(9, 0) == 0) begin
          w = $urandom_range(300, 200);
          h = 1;
        end else begin
          w = $urandom_range(24, 1);
          h = $urandom_range(8, 1);
        end
        write_setup(pick_level(), pick_level(), pick_level(), pick_threshold(),
                    CFG_SIZE_W'(w), CFG_SIZE_W'(h), 1'($urandom_range(1, 0)));
      end
      case ($urandom_range(3, 0))
        0: pct = 0;
        1: pct = 3;
        2: pct = 15;
        default: pct = 60;
      endcase
      if ($urandom_range(7, 0) == 0) begin
        // Stop part-way, change the size with the raster mid-frame, then finish.
        cut = $urandom_range(clamp_size(width_setting) * clamp_size(height_setting), 1);
        repeat (cut) begin
          p = make_pixel(pct);
          send_rgba(p.red, p.green, p.blue, p.alpha);
        end
        write_setup(colour_cfg.bg.red, colour_cfg.bg.green, colour_cfg.bg.blue,
                    colour_cfg.threshold, CFG_SIZE_W'($urandom_range(24, 1)),
                    CFG_SIZE_W'($urandom_range(8, 1)), colour_cfg.alpha_en);
      end
      send_frame_rest(pct);
      // Now and then hold the sender until every result item has drained.
      if (frame_no % 5 == 4) settle_block();
      frame_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_BG_RED;
    cfg_wdata_i   <= '0;
    pix.valid     <= 1'b0;
    pix.pix_red   <= '0;
    pix.pix_green <= '0;
    pix.pix_blue  <= '0;
    pix.pix_alpha <= '0;

    // Mirror the register defaults that reset loads.
    colour_cfg.bg        = '0;
    colour_cfg.threshold = THRESH_RESET;
    colour_cfg.alpha_en  = 1'b1;
    width_setting        = CFG_SIZE_W'(MAX_DIM_DEF);
    height_setting       = CFG_SIZE_W'(MAX_DIM_DEF);
    clear_raster();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_size_change_mid_frame();
    test_tiny_frames();
    test_blend_extremes();
    test_long_edges();
    test_random_frames();

    // Drain everything and give a stray extra result item time to show up.
    settle_block();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
